[sv/rcpc_pkg.sv]
`default_nettype none
package rcpc_pkg;

	localparam int NUM_CH = 4;
	localparam int CH_W = 2;
	localparam int MODE_W = 3;
	localparam int WIDTH_W = 16;
	localparam int AXIS_W = 8;
	localparam int QUO_W = 7;
	localparam int MAG_W = WIDTH_W + QUO_W;
	localparam int DSH_W = WIDTH_W + QUO_W - 1;

	localparam logic [1:0] CMD_EDGE = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_CAL = 2'd2;

	localparam logic [MODE_W-1:0] MODE_RESET = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIRST = 3'd1;
	localparam logic [MODE_W-1:0] MODE_LAST = 3'd4;

	localparam logic [WIDTH_W-1:0] RANGE_LOW_RESET = 16'd1200;
	localparam logic [WIDTH_W-1:0] RANGE_HIGH_RESET = 16'd1800;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX = 16'hFFFF;
	localparam logic [QUO_W-1:0] OUT_SPAN = 7'd100;
	localparam logic [AXIS_W-1:0] OUT_OFFSET = 8'd50;

	// channel feeding throttle, yaw, pitch, roll for modes 1 to 4
	localparam logic [CH_W-1:0] ROUTE_TAB [4][4] = '{
		'{2'd1, 2'd3, 2'd2, 2'd0},
		'{2'd2, 2'd3, 2'd1, 2'd0},
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd1, 2'd3}
	};

	typedef enum logic [1:0] {
		OP_EDGE,
		OP_UPDATE,
		OP_CAL
	} op_t;

	typedef struct packed {
		op_t op;
		logic [CH_W-1:0] channel;
		logic [31:0] time_us;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SAT,
		ST_DIV,
		ST_ROUTE,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

[sv/rcpc_front.sv]
`default_nettype none
module rcpc_front (
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             command,
	input  wire logic [1:0]             channel,
	input  wire logic [31:0]            time_us,
	input  wire logic                   q_full,
	output logic                        q_push,
	output rcpc_pkg::item_t             q_item
);
	import rcpc_pkg::*;

	logic known;

	always_comb begin
		known = 1'b1;
		q_item.op = OP_EDGE;
		unique case (command)
			CMD_EDGE: q_item.op = OP_EDGE;
			CMD_UPDATE: q_item.op = OP_UPDATE;
			CMD_CAL: q_item.op = OP_CAL;
			default: known = 1'b0;
		endcase
		q_item.channel = channel;
		q_item.time_us = time_us;
	end

	// drop unknown commands at the door
	assign in_stall = q_full;
	assign q_push = in_valid && !q_full && known;

endmodule
`default_nettype wire

[sv/rcpc_fifo.sv]
`default_nettype none
module rcpc_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire rcpc_pkg::item_t push_item,
	output logic             full,
	input  wire logic        pop,
	output rcpc_pkg::item_t  head,
	output logic             empty
);
	import rcpc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/rcpc_back.sv]
`default_nettype none
module rcpc_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	input  wire rcpc_pkg::item_t head,
	input  wire logic        q_empty,
	output logic             q_pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       throttle,
	output logic [7:0]       yaw,
	output logic [7:0]       pitch,
	output logic [7:0]       roll,
	output logic             mode_error
);
	import rcpc_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [MODE_W-1:0]  mode_q;
	logic [31:0]        edge_start_q [NUM_CH];
	logic [NUM_CH-1:0]  armed_q;
	logic [WIDTH_W-1:0] pulse_width_q [NUM_CH];
	logic [WIDTH_W-1:0] range_low_q [NUM_CH];
	logic [WIDTH_W-1:0] range_high_q [NUM_CH];
	logic [AXIS_W-1:0]  hold_q [4];
	logic [AXIS_W-1:0]  vals_q [NUM_CH];
	logic               err_q;

	logic [CH_W-1:0]    ch_q;
	logic [MAG_W-1:0]   mag_q;
	logic [MAG_W-1:0]   rem_q;
	logic [WIDTH_W-1:0] den_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [2:0]         bit_q;
	logic               low_q;
	logic               sat_q;

	logic               out_valid_q;
	logic [AXIS_W-1:0]  out_axis_q [4];
	logic               out_err_q;

	logic               mode_ok;
	logic [1:0]         mode_idx;
	logic               emit_load;
	logic [31:0]        delta;
	logic [WIDTH_W-1:0] w_cur;
	logic [WIDTH_W-1:0] lo_cur;
	logic [WIDTH_W-1:0] hi_cur;
	logic [MAG_W-1:0]   mag_d;
	logic               div_ge;
	logic [MAG_W-1:0]   rem_d;
	logic [QUO_W-1:0]   quo_d;
	logic [QUO_W-1:0]   quo_full;
	logic [QUO_W-1:0]   quo_clamp;
	logic [AXIS_W-1:0]  val_d;

	assign cfg_ready = 1'b1;
	assign mode_ok = (mode_q >= MODE_FIRST) && (mode_q <= MODE_LAST);
	assign mode_idx = 2'(mode_q - MODE_FIRST);

	assign delta = head.time_us - edge_start_q[head.channel];
	assign w_cur = pulse_width_q[ch_q];
	assign lo_cur = range_low_q[ch_q];
	assign hi_cur = range_high_q[ch_q];
	assign mag_d = MAG_W'(w_cur - lo_cur) * MAG_W'(OUT_SPAN);

	assign div_ge = rem_q >= MAG_W'(dsh_q);
	assign rem_d = div_ge ? rem_q - MAG_W'(dsh_q) : rem_q;

	always_comb begin
		quo_d = quo_q;
		quo_d[bit_q] = div_ge;
		quo_full = sat_q ? '1 : quo_d;
		quo_clamp = low_q ? '0 : ((quo_full > OUT_SPAN) ? OUT_SPAN : quo_full);
		val_d = AXIS_W'(quo_clamp) - ((ch_q == '0) ? '0 : OUT_OFFSET);
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (head.op == OP_UPDATE) begin
						state_d = mode_ok ? ST_MUL : ST_EMIT;
					end
				end
			end
			ST_MUL: state_d = ST_SAT;
			ST_SAT: state_d = ST_DIV;
			ST_DIV: begin
				if (bit_q == '0) begin
					state_d = (ch_q == CH_W'(NUM_CH - 1)) ? ST_ROUTE : ST_MUL;
				end
			end
			ST_ROUTE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
			armed_q <= '0;
			err_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CH; i++) begin
				edge_start_q[i] <= '0;
				pulse_width_q[i] <= '0;
				range_low_q[i] <= RANGE_LOW_RESET;
				range_high_q[i] <= RANGE_HIGH_RESET;
			end
			for (int a = 0; a < 4; a++) begin
				hold_q[a] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (q_pop) begin
				unique case (head.op)
					OP_EDGE: begin
						if (!armed_q[head.channel]) begin
							edge_start_q[head.channel] <= head.time_us;
							armed_q[head.channel] <= 1'b1;
						end else begin
							pulse_width_q[head.channel] <= (delta > 32'(WIDTH_MAX)) ?
								WIDTH_MAX : delta[WIDTH_W-1:0];
							armed_q[head.channel] <= 1'b0;
						end
					end
					OP_CAL: begin
						for (int i = 0; i < NUM_CH; i++) begin
							if (pulse_width_q[i] < range_low_q[i]) begin
								range_low_q[i] <= pulse_width_q[i];
							end
							if (pulse_width_q[i] > range_high_q[i]) begin
								range_high_q[i] <= pulse_width_q[i];
							end
						end
					end
					OP_UPDATE: begin
						if (!mode_ok) begin
							err_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_ROUTE) begin
				for (int a = 0; a < 4; a++) begin
					hold_q[a] <= vals_q[ROUTE_TAB[mode_idx][a]];
				end
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ch_q <= '0;
		end
		unique case (state_q)
			ST_MUL: begin
				mag_q <= mag_d;
				den_q <= hi_cur - lo_cur;
				low_q <= (w_cur <= lo_cur) || (hi_cur == lo_cur);
			end
			ST_SAT: begin
				rem_q <= mag_q;
				sat_q <= mag_q >= {den_q, QUO_W'(0)};
				dsh_q <= {den_q, (QUO_W - 1)'(0)};
				quo_q <= '0;
				bit_q <= 3'(QUO_W - 1);
			end
			ST_DIV: begin
				rem_q <= rem_d;
				quo_q <= quo_d;
				dsh_q <= dsh_q >> 1;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					vals_q[ch_q] <= val_d;
					ch_q <= ch_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (emit_load) begin
			for (int a = 0; a < 4; a++) begin
				out_axis_q[a] <= hold_q[a];
			end
			out_err_q <= err_q;
		end
	end

	assign out_valid = out_valid_q;
	assign throttle = out_axis_q[0];
	assign yaw = out_axis_q[1];
	assign pitch = out_axis_q[2];
	assign roll = out_axis_q[3];
	assign mode_error = out_err_q;

endmodule
`default_nettype wire

[sv/rc_pulse_capture_axis_map_core.sv]
// Four-channel RC pulse capture and axis mapper.
// Input channel (in_valid / in_stall): command, channel, time_us. Command 0 is
// an edge on a channel: the first edge arms it, the next stores the pulse width
// (saturated at 65535 us). Command 1 maps all widths onto axes and produces one
// transfer on the output channel. Command 2 widens every calibrated range with
// the latest width. Command 3 is dropped without a result.
// Items enter a short queue and are executed one at a time. Edge and calibrate
// items are executed as they leave the queue. An update in a valid axis_mode runs
// each of the four channels through a multiply step, a range check and seven
// steps of the shared restoring divider, then axis routing and the output load.
// Output channel (out_valid / out_stall): throttle, yaw, pitch, roll and
// mode_error, held in an output register; while the receiver stalls, the
// queue still accepts items until it fills, then in_stall rises.
// Config channel (cfg_valid / cfg_ready, always ready): axis_mode, to be
// written while idle; the block does not enforce this. Reset clears all widths,
// sets ranges to 1200..1800, held axis values to 0 and axis_mode to 1.
`default_nettype none
module rc_pulse_capture_axis_map_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [1:0]  channel,
	input  wire logic [31:0] time_us,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       throttle,
	output logic [7:0]       yaw,
	output logic [7:0]       pitch,
	output logic [7:0]       roll,
	output logic             mode_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data
);
	import rcpc_pkg::*;

	item_t push_item;
	item_t head;
	logic push;
	logic full;
	logic empty;
	logic pop;

	rcpc_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.channel  (channel),
		.time_us  (time_us),
		.q_full   (full),
		.q_push   (push),
		.q_item   (push_item)
	);

	rcpc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	rcpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.head       (head),
		.q_empty    (empty),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.throttle   (throttle),
		.yaw        (yaw),
		.pitch      (pitch),
		.roll       (roll),
		.mode_error (mode_error)
	);

endmodule
`default_nettype wire
